### rtl/core/lik_pkg.sv
// Shared types, widths and constants of the leg inverse kinematics solver.
`timescale 1ns / 1ps
package lik_pkg;

   // Field and register widths.
   localparam int COORD_W    = 11;
   localparam int ANGLE_FRAC = 6;
   localparam int LEG_W      = 8;
   localparam int LEN_W      = 8;
   localparam int BIAS_W     = 9;
   localparam int CSR_W      = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int STATUS_W   = 2;
   localparam int CHAN_W     = 4;
   localparam int OUT_W      = 16;

   // Datapath widths of the geometry pipeline.
   localparam int POS_W  = COORD_W + 1;
   localparam int SQ_W   = 2 * POS_W;
   localparam int XY2_W  = SQ_W + 1;
   localparam int D2_W   = SQ_W + 2;
   localparam int LSQ_W  = 2 * LEN_W;
   localparam int TH_W   = 2 * LSQ_W;
   localparam int DH_W   = D2_W + LSQ_W;
   localparam int CE_W   = D2_W + 1;
   localparam int RAD_W  = 2 * CE_W - 2;
   localparam int DISC_W = RAD_W + 1;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int MAG_W  = ROOT_W;
   localparam int XY_SH  = 16;
   localparam int FLAT_SH = 8;

   // CORDIC arctangent unit.
   localparam int CORDIC_FRAC  = 16;
   localparam int CORDIC_STEPS = 18;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 3;
   localparam int XY_W         = MAG_W + 9;
   localparam int ACC_W        = CORDIC_FRAC + 10;
   localparam int NORM_TOP     = 30;
   localparam int SH_W         = 5;
   localparam int ANG_W        = ANGLE_FRAC + 8;
   localparam int RND_SH       = CORDIC_FRAC - ANGLE_FRAC;
   localparam int SUM_W        = ANG_W + 4;

   localparam logic signed [ACC_W-1:0] ACC_90   = ACC_W'(90 << CORDIC_FRAC);
   localparam logic signed [ACC_W-1:0] ACC_180  = ACC_W'(180 << CORDIC_FRAC);
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (RND_SH - 1));

   localparam logic signed [SUM_W-1:0] ANG_90  = SUM_W'(90 << ANGLE_FRAC);
   localparam logic signed [SUM_W-1:0] ANG_180 = SUM_W'(180 << ANGLE_FRAC);
   localparam logic signed [SUM_W-1:0] ANG_LIM = SUM_W'(360 << ANGLE_FRAC);

   // atan(2^-i) in degrees with CORDIC_FRAC fractional bits.
   localparam logic signed [ACC_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
      7334, 3667, 1833, 917, 458, 229, 115, 57, 29
   };

   // Register reset values.
   localparam logic [LEN_W-1:0]         RST_THIGH_REAR  = 8'd70;
   localparam logic [LEN_W-1:0]         RST_THIGH_FRONT = 8'd60;
   localparam logic [LEN_W-1:0]         RST_TIBIA_LEN   = 8'd80;
   localparam logic [LEN_W-1:0]         RST_HIP_OFFSET  = 8'd49;
   localparam logic signed [BIAS_W-1:0] RST_HIP_BIAS    = -9'sd67;
   localparam logic [LEN_W-1:0]         RST_TIBIA_BIAS  = 8'd40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THIGH_REAR  = 3'd0,
      CSR_THIGH_FRONT = 3'd1,
      CSR_TIBIA_LEN   = 3'd2,
      CSR_HIP_OFFSET  = 3'd3,
      CSR_HIP_BIAS    = 3'd4,
      CSR_TIBIA_BIAS  = 3'd5
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_LEG = 2'd1,
      ST_UNREACH = 2'd2
   } status_type;

   typedef struct packed {
      logic                    bad_leg;
      logic [1:0]              leg;
      logic                    zero;
      logic                    far;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } meta_type;

   typedef struct packed {
      meta_type               meta;
      logic signed [CE_W-1:0] c;
      logic signed [CE_W-1:0] e;
   } side_type;

   typedef struct packed {
      logic       bad_leg;
      logic [1:0] leg;
      logic       zero;
      logic       far;
   } flag_type;

endpackage

### rtl/core/lik_atan2.sv
// Pipelined CORDIC arctangent for a non-negative y, result in [0, 180] degrees.
`timescale 1ns / 1ps
module lik_atan2 import lik_pkg::*; (
   input  logic                   clock,
   input  logic [MAG_W-1:0]       in_y,
   input  logic signed [CE_W-1:0] in_x,
   output logic [ANG_W-1:0]       angle
);

   logic [MAG_W-1:0] na_ux_ff, na_uy_ff, na_ux_in, na_uy_in;
   logic [SH_W-1:0]  na_sh_ff, na_sh_in;
   logic             na_base_ff, na_base_in, na_zero_ff, na_zero_in;

   logic signed [XY_W-1:0]  cx_ff [CORDIC_STEPS+1];
   logic signed [XY_W-1:0]  cy_ff [CORDIC_STEPS+1];
   logic signed [ACC_W-1:0] ca_ff [CORDIC_STEPS+1];
   logic                    cz_ff [CORDIC_STEPS+1];
   logic signed [XY_W-1:0]  cx_in [CORDIC_STEPS+1];
   logic signed [XY_W-1:0]  cy_in [CORDIC_STEPS+1];
   logic signed [ACC_W-1:0] ca_in [CORDIC_STEPS+1];
   logic                    cz_in [CORDIC_STEPS+1];

   logic [ANG_W-1:0] angle_ff, angle_in;

   // A negative x is rotated by 90 degrees, then the larger component is
   // brought up to bit NORM_TOP.
   always_comb begin
      logic signed [CE_W-1:0] neg_x;
      logic [MAG_W-1:0]       mag;
      logic [SH_W-1:0]        msb;
      neg_x = -in_x;
      if (in_x[CE_W-1]) begin
         na_ux_in   = in_y;
         na_uy_in   = neg_x[MAG_W-1:0];
         na_base_in = 1'b1;
      end else begin
         na_ux_in   = in_x[MAG_W-1:0];
         na_uy_in   = in_y;
         na_base_in = 1'b0;
      end
      mag = (na_ux_in > na_uy_in) ? na_ux_in : na_uy_in;
      msb = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (mag[b]) msb = SH_W'(b);
      end
      na_sh_in   = SH_W'(NORM_TOP) - msb;
      na_zero_in = (in_y == '0) && (in_x == '0);
   end

   always_comb begin
      cx_in[0] = $signed(XY_W'(na_ux_ff)) <<< na_sh_ff;
      cy_in[0] = $signed(XY_W'(na_uy_ff)) <<< na_sh_ff;
      ca_in[0] = na_base_ff ? ACC_90 : '0;
      cz_in[0] = na_zero_ff;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (!cy_ff[i][XY_W-1]) begin
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            ca_in[i+1] = ca_ff[i] + ATAN_TABLE[i];
         end else begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            ca_in[i+1] = ca_ff[i] - ATAN_TABLE[i];
         end
         cz_in[i+1] = cz_ff[i];
      end
   end

   // Clamp to [0, 180] degrees and round half up to the output grid; a zero input gives zero.
   always_comb begin
      logic signed [ACC_W-1:0] clamped;
      logic signed [ACC_W-1:0] rnd;
      clamped = ca_ff[CORDIC_STEPS];
      if (clamped < 0) clamped = '0;
      else if (clamped > ACC_180) clamped = ACC_180;
      rnd = clamped + RND_HALF;
      angle_in = cz_ff[CORDIC_STEPS] ? '0 : rnd[RND_SH +: ANG_W];
   end

   always_ff @(posedge clock) begin
      na_ux_ff   <= na_ux_in;
      na_uy_ff   <= na_uy_in;
      na_sh_ff   <= na_sh_in;
      na_base_ff <= na_base_in;
      na_zero_ff <= na_zero_in;
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
         cx_ff[i] <= cx_in[i];
         cy_ff[i] <= cy_in[i];
         ca_ff[i] <= ca_in[i];
         cz_ff[i] <= cz_in[i];
      end
      angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

### rtl/core/leg_inverse_kinematics.sv
// Top level of the pipelined three-joint leg inverse kinematics solver.
`timescale 1ns / 1ps
// The solver takes one foot target per clock cycle and returns the hip, thigh
// and tibia servo angles of a three-joint leg, in 1/64 degree, with a status
// and the leg's base servo channel.
// A transaction is accepted at a rising edge where start is high and busy is
// low; busy is high only while reset is held, so one transaction can enter in
// every cycle. Each result appears on the rsp_ ports for exactly one cycle,
// marked by rsp_valid, in order of acceptance. It passes through 55 register
// stages: seven stages of squares and products, a square root of one result
// bit per stage (26 stages) and an 18-step CORDIC unit with normalisation and
// rounding (21 stages), plus the output register.
// The receiver cannot hold results off, so nothing in the pipeline stalls.
// Reset, synchronous and active high, empties the pipeline and returns the
// six csr_ registers to their default lengths and biases. The registers are
// written with csr_write_en, csr_index and csr_wdata, by the user only while no
// transaction is in flight, as the block does not enforce it; reads are live.
module leg_inverse_kinematics import lik_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [LEG_W-1:0]          req_leg,
   input  logic signed [COORD_W-1:0] req_target_x,
   input  logic signed [COORD_W-1:0] req_target_y,
   input  logic signed [COORD_W-1:0] req_target_z,
   input  logic                      csr_write_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [CHAN_W-1:0]         rsp_base_channel,
   output logic signed [OUT_W-1:0]   rsp_hip_servo,
   output logic signed [OUT_W-1:0]   rsp_thigh_servo,
   output logic signed [OUT_W-1:0]   rsp_tibia_servo
);

   localparam int LANE_THIGH = 0;
   localparam int LANE_TIBIA = 1;
   localparam int LANE_XY    = 2;
   localparam int LATENCY    = 6 + (ROOT_W + 1) + CORDIC_LAT + 1;

   // Configuration registers.
   logic [LEN_W-1:0]         thigh_rear_ff, thigh_front_ff, tibia_len_ff, hip_ofs_ff;
   logic signed [BIAS_W-1:0] hip_bias_ff;
   logic [LEN_W-1:0]         tibia_bias_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thigh_rear_ff  <= RST_THIGH_REAR;
         thigh_front_ff <= RST_THIGH_FRONT;
         tibia_len_ff   <= RST_TIBIA_LEN;
         hip_ofs_ff     <= RST_HIP_OFFSET;
         hip_bias_ff    <= RST_HIP_BIAS;
         tibia_bias_ff  <= RST_TIBIA_BIAS;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_THIGH_REAR:  thigh_rear_ff  <= csr_wdata[LEN_W-1:0];
            CSR_THIGH_FRONT: thigh_front_ff <= csr_wdata[LEN_W-1:0];
            CSR_TIBIA_LEN:   tibia_len_ff   <= csr_wdata[LEN_W-1:0];
            CSR_HIP_OFFSET:  hip_ofs_ff     <= csr_wdata[LEN_W-1:0];
            CSR_HIP_BIAS:    hip_bias_ff    <= $signed(csr_wdata[BIAS_W-1:0]);
            CSR_TIBIA_BIAS:  tibia_bias_ff  <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // Stage registers ahead of the square root.
   logic     s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   meta_type s1_meta_ff, s2_meta_ff, s3_meta_ff, s4_meta_ff, s5_meta_ff, s6_meta_ff;
   meta_type s1_meta_in, s4_meta_in;

   logic [LEN_W-1:0]  s1_h_ff, s1_t_ff, s1_h_in;
   logic [SQ_W-1:0]   s2_xx_ff, s2_yy_ff, s2_zz_ff, s3_zz_ff;
   logic [LSQ_W-1:0]  s2_hh_ff, s2_tt_ff, s3_hh_ff, s3_tt_ff, s4_hh_ff, s4_tt_ff;
   logic [XY2_W-1:0]  s3_xy2_ff, s4_xy2_ff, s5_xy2_ff, s6_xy2_ff;
   logic [D2_W-1:0]   s4_d2_ff;
   logic [LSQ_W:0]    s4_sumth_ff;
   logic signed [LSQ_W:0] s4_difht_ff;
   logic signed [CE_W-1:0] s5_c_ff, s5_e_ff, s6_c_ff, s6_e_ff;
   logic [TH_W-1:0]   s5_th_ff, s6_th_ff;
   logic [DH_W-1:0]   s5_dh_ff, s6_dh_ff;
   logic [RAD_W-1:0]  s6_cc_ff, s6_ee_ff;

   logic signed [SQ_W-1:0]   s2_xx_in, s2_yy_in, s2_zz_in;
   logic signed [2*CE_W-1:0] s6_cc_in, s6_ee_in;

   // Target x and y less the hip offset, leg check and thigh length.
   always_comb begin
      s1_meta_in         = '0;
      s1_meta_in.bad_leg = |req_leg[LEG_W-1:2];
      s1_meta_in.leg     = req_leg[1:0];
      s1_meta_in.x = $signed({{(POS_W-COORD_W){req_target_x[COORD_W-1]}}, req_target_x})
                     - $signed({{(POS_W-LEN_W){1'b0}}, hip_ofs_ff});
      s1_meta_in.y = $signed({{(POS_W-COORD_W){req_target_y[COORD_W-1]}}, req_target_y})
                     - $signed({{(POS_W-LEN_W){1'b0}}, hip_ofs_ff});
      s1_meta_in.z = $signed({{(POS_W-COORD_W){req_target_z[COORD_W-1]}}, req_target_z});
      s1_h_in      = req_leg[1] ? thigh_front_ff : thigh_rear_ff;
   end

   always_comb begin
      s2_xx_in = s1_meta_ff.x * s1_meta_ff.x;
      s2_yy_in = s1_meta_ff.y * s1_meta_ff.y;
      s2_zz_in = s1_meta_ff.z * s1_meta_ff.z;
      s4_meta_in      = s3_meta_ff;
      s4_meta_in.zero = (s3_xy2_ff == '0);
      s6_cc_in = s5_c_ff * s5_c_ff;
      s6_ee_in = s5_e_ff * s5_e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      // Stage 1.
      s1_meta_ff <= s1_meta_in;
      s1_h_ff    <= s1_h_in;
      s1_t_ff    <= tibia_len_ff;
      // Stage 2: squares.
      s2_meta_ff <= s1_meta_ff;
      s2_xx_ff   <= $unsigned(s2_xx_in);
      s2_yy_ff   <= $unsigned(s2_yy_in);
      s2_zz_ff   <= $unsigned(s2_zz_in);
      s2_hh_ff   <= LSQ_W'(s1_h_ff) * LSQ_W'(s1_h_ff);
      s2_tt_ff   <= LSQ_W'(s1_t_ff) * LSQ_W'(s1_t_ff);
      // Stage 3: planar reach squared.
      s3_meta_ff <= s2_meta_ff;
      s3_xy2_ff  <= XY2_W'(s2_xx_ff) + XY2_W'(s2_yy_ff);
      s3_zz_ff   <= s2_zz_ff;
      s3_hh_ff   <= s2_hh_ff;
      s3_tt_ff   <= s2_tt_ff;
      // Stage 4: spatial reach squared and the sum and difference of squared lengths.
      s4_meta_ff  <= s4_meta_in;
      s4_xy2_ff   <= s3_xy2_ff;
      s4_d2_ff    <= D2_W'(s3_xy2_ff) + D2_W'(s3_zz_ff);
      s4_sumth_ff <= (LSQ_W+1)'(s3_tt_ff) + (LSQ_W+1)'(s3_hh_ff);
      s4_difht_ff <= $signed({1'b0, s3_hh_ff}) - $signed({1'b0, s3_tt_ff});
      s4_hh_ff    <= s3_hh_ff;
      s4_tt_ff    <= s3_tt_ff;
      // Stage 5: law of cosines numerators and the discriminant products.
      s5_meta_ff <= s4_meta_ff;
      s5_xy2_ff  <= s4_xy2_ff;
      s5_c_ff    <= $signed(CE_W'(s4_sumth_ff)) - $signed(CE_W'(s4_d2_ff));
      s5_e_ff    <= $signed(CE_W'(s4_d2_ff)) + CE_W'(s4_difht_ff);
      s5_th_ff   <= TH_W'(s4_tt_ff) * TH_W'(s4_hh_ff);
      s5_dh_ff   <= DH_W'(s4_d2_ff) * DH_W'(s4_hh_ff);
      // Stage 6: squared numerators.
      s6_meta_ff <= s5_meta_ff;
      s6_xy2_ff  <= s5_xy2_ff;
      s6_c_ff    <= s5_c_ff;
      s6_e_ff    <= s5_e_ff;
      s6_th_ff   <= s5_th_ff;
      s6_dh_ff   <= s5_dh_ff;
      s6_cc_ff   <= s6_cc_in[RAD_W-1:0];
      s6_ee_ff   <= s6_ee_in[RAD_W-1:0];
   end

   // Square root lanes, one result bit per stage. Entry 0 holds the two
   // discriminants and planar reach squared; entry ROOT_W holds the finished roots.
   logic [RAD_W-1:0]  sq_rad_ff  [3][ROOT_W+1];
   logic [REM_W-1:0]  sq_rem_ff  [3][ROOT_W+1];
   logic [ROOT_W-1:0] sq_root_ff [3][ROOT_W+1];
   logic [RAD_W-1:0]  sq_rad_in  [3][ROOT_W+1];
   logic [REM_W-1:0]  sq_rem_in  [3][ROOT_W+1];
   logic [ROOT_W-1:0] sq_root_in [3][ROOT_W+1];
   side_type          sq_side_ff [ROOT_W+1];
   side_type          sq_side_in [ROOT_W+1];
   logic              sq_vld_ff  [ROOT_W+1];

   always_comb begin
      logic signed [DISC_W-1:0] disc1;
      logic signed [DISC_W-1:0] disc2;
      logic [REM_W-1:0]         rem_sh;
      logic [REM_W-1:0]         trial;
      disc1 = $signed(DISC_W'({s6_th_ff, 2'b00})) - $signed({1'b0, s6_cc_ff});
      disc2 = $signed(DISC_W'({s6_dh_ff, 2'b00})) - $signed({1'b0, s6_ee_ff});
      sq_rad_in[LANE_THIGH][0] = disc1[RAD_W-1:0];
      sq_rad_in[LANE_TIBIA][0] = disc2[RAD_W-1:0];
      sq_rad_in[LANE_XY][0]    = RAD_W'({s6_xy2_ff, {XY_SH{1'b0}}});
      for (int k = 0; k < 3; k++) begin
         sq_rem_in[k][0]  = '0;
         sq_root_in[k][0] = '0;
      end
      sq_side_in[0]          = '0;
      sq_side_in[0].meta     = s6_meta_ff;
      sq_side_in[0].meta.far = disc1[DISC_W-1] | disc2[DISC_W-1];
      sq_side_in[0].c        = s6_c_ff;
      sq_side_in[0].e        = s6_e_ff;
      for (int j = 0; j < ROOT_W; j++) begin
         for (int k = 0; k < 3; k++) begin
            rem_sh = {sq_rem_ff[k][j][REM_W-3:0], sq_rad_ff[k][j][RAD_W-1 -: 2]};
            trial  = {sq_root_ff[k][j], 2'b01};
            if (rem_sh >= trial) begin
               sq_rem_in[k][j+1]  = rem_sh - trial;
               sq_root_in[k][j+1] = {sq_root_ff[k][j][ROOT_W-2:0], 1'b1};
            end else begin
               sq_rem_in[k][j+1]  = rem_sh;
               sq_root_in[k][j+1] = {sq_root_ff[k][j][ROOT_W-2:0], 1'b0};
            end
            sq_rad_in[k][j+1] = {sq_rad_ff[k][j][RAD_W-3:0], 2'b00};
         end
         sq_side_in[j+1] = sq_side_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= ROOT_W; j++) begin
         for (int k = 0; k < 3; k++) begin
            sq_rad_ff[k][j]  <= sq_rad_in[k][j];
            sq_rem_ff[k][j]  <= sq_rem_in[k][j];
            sq_root_ff[k][j] <= sq_root_in[k][j];
         end
         sq_side_ff[j] <= sq_side_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= ROOT_W; j++) sq_vld_ff[j] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= s6_vld_ff;
         for (int j = 0; j < ROOT_W; j++) sq_vld_ff[j+1] <= sq_vld_ff[j];
      end
   end

   // Four arctangents: hip, flat elevation, thigh and tibia.
   side_type               sq_out;
   logic signed [POS_W-1:0] abs_y, abs_z;
   logic [MAG_W-1:0]        hip_yin, flat_yin;
   logic [ANG_W-1:0]        hip_ang, flat_ang, thigh_ang, tibia_ang;

   always_comb begin
      sq_out   = sq_side_ff[ROOT_W];
      abs_y    = sq_out.meta.y[POS_W-1] ? -sq_out.meta.y : sq_out.meta.y;
      abs_z    = sq_out.meta.z[POS_W-1] ? -sq_out.meta.z : sq_out.meta.z;
      hip_yin  = MAG_W'($unsigned(abs_y));
      flat_yin = MAG_W'($unsigned(abs_z)) << FLAT_SH;
   end

   lik_atan2 u_hip (
      .clock (clock),
      .in_y  (hip_yin),
      .in_x  (CE_W'(sq_out.meta.x)),
      .angle (hip_ang)
   );

   lik_atan2 u_flat (
      .clock (clock),
      .in_y  (flat_yin),
      .in_x  ($signed({1'b0, sq_root_ff[LANE_XY][ROOT_W]})),
      .angle (flat_ang)
   );

   lik_atan2 u_thigh (
      .clock (clock),
      .in_y  (sq_root_ff[LANE_THIGH][ROOT_W]),
      .in_x  (sq_out.c),
      .angle (thigh_ang)
   );

   lik_atan2 u_tibia (
      .clock (clock),
      .in_y  (sq_root_ff[LANE_TIBIA][ROOT_W]),
      .in_x  (sq_out.e),
      .angle (tibia_ang)
   );

   // Status flags ride alongside the CORDIC units.
   flag_type cd_flag_ff [CORDIC_LAT];
   logic     cd_vld_ff  [CORDIC_LAT];

   always_ff @(posedge clock) begin
      cd_flag_ff[0].bad_leg <= sq_out.meta.bad_leg;
      cd_flag_ff[0].leg     <= sq_out.meta.leg;
      cd_flag_ff[0].zero    <= sq_out.meta.zero;
      cd_flag_ff[0].far     <= sq_out.meta.far;
      for (int j = 1; j < CORDIC_LAT; j++) cd_flag_ff[j] <= cd_flag_ff[j-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < CORDIC_LAT; j++) cd_vld_ff[j] <= 1'b0;
      end else begin
         cd_vld_ff[0] <= sq_vld_ff[ROOT_W];
         for (int j = 1; j < CORDIC_LAT; j++) cd_vld_ff[j] <= cd_vld_ff[j-1];
      end
   end

   // Joint angles, saturation and status.
   function automatic logic [OUT_W-1:0] sat_angle(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = v;
      if (v > ANG_LIM) r = ANG_LIM;
      else if (v < -ANG_LIM) r = -ANG_LIM;
      return r[OUT_W-1:0];
   endfunction

   flag_type                 fin_flag;
   logic signed [SUM_W-1:0]  hip_sum, thigh_sum, tibia_sum;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [CHAN_W-1:0]        rsp_chan_ff, rsp_chan_in;
   logic [OUT_W-1:0]         rsp_hip_ff, rsp_thigh_ff, rsp_tibia_ff;
   logic [OUT_W-1:0]         rsp_hip_in, rsp_thigh_in, rsp_tibia_in;
   logic                     rsp_valid_ff;

   always_comb begin
      fin_flag  = cd_flag_ff[CORDIC_LAT-1];
      hip_sum   = ANG_180 - $signed(SUM_W'(hip_ang))
                  + $signed({{(SUM_W-BIAS_W-ANGLE_FRAC){hip_bias_ff[BIAS_W-1]}},
                             hip_bias_ff, {ANGLE_FRAC{1'b0}}});
      thigh_sum = $signed(SUM_W'(thigh_ang)) - $signed(SUM_W'(flat_ang)) + ANG_90;
      tibia_sum = $signed(SUM_W'(tibia_ang))
                  - $signed(SUM_W'({tibia_bias_ff, {ANGLE_FRAC{1'b0}}}));
      rsp_status_in = ST_OK;
      rsp_chan_in   = {fin_flag.leg, 2'b00};
      rsp_hip_in    = sat_angle(hip_sum);
      rsp_thigh_in  = sat_angle(thigh_sum);
      rsp_tibia_in  = sat_angle(tibia_sum);
      if (fin_flag.bad_leg) begin
         rsp_status_in = ST_BAD_LEG;
         rsp_chan_in   = '0;
         rsp_hip_in    = '0;
         rsp_thigh_in  = '0;
         rsp_tibia_in  = '0;
      end else if (fin_flag.zero || fin_flag.far) begin
         rsp_status_in = ST_UNREACH;
         rsp_hip_in    = '0;
         rsp_thigh_in  = '0;
         rsp_tibia_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_hip_ff    <= rsp_hip_in;
      rsp_thigh_ff  <= rsp_thigh_in;
      rsp_tibia_ff  <= rsp_tibia_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cd_vld_ff[CORDIC_LAT-1];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_base_channel = rsp_chan_ff;
   assign rsp_hip_servo    = $signed(rsp_hip_ff);
   assign rsp_thigh_servo  = $signed(rsp_thigh_ff);
   assign rsp_tibia_servo  = $signed(rsp_tibia_ff);

   // Every accepted transaction yields its result after the fixed latency.
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after an accepted transaction");

   // No result appears without a transaction accepted that many edges before.
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching transaction");

   // A rejected leg carries no channel and no angles.
   a_bad_leg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BAD_LEG) |->
         (rsp_base_channel == '0 && rsp_hip_servo == '0 &&
          rsp_thigh_servo == '0 && rsp_tibia_servo == '0))
      else $error("invalid leg result carries data");

endmodule
